FILE: hw/rtl/kvt_pkg.sv
// shared types, sizes and operation codes of the key/value table
package kvt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam idx_t LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam cnt_t MAX_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_ACCESS   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_ERASE    = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef struct packed {
    key_t   key;
    value_t value;
  } slot_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    logic  inval_en;
    idx_t  wr_addr;
    slot_t wr_data;
    logic  clr_all;
  } mem_req_t;

  typedef struct packed {
    logic  valid;
    slot_t data;
  } mem_rsp_t;

  typedef struct packed {
    logic        is_empty;
    logic [4:0]  entry_count;
    logic        rejected;
    logic [31:0] value_out;
    logic        found;
  } res_t;

endpackage

FILE: hw/rtl/kvt_slot_store.sv
// slot memory with registered read port and per-slot valid flags
module kvt_slot_store (
  input  logic              clk,
  input  logic              rst_n,
  input  kvt_pkg::mem_req_t mem_req,
  output kvt_pkg::mem_rsp_t mem_rsp
);

  kvt_pkg::slot_t                       slot_mem [kvt_pkg::TABLE_ENTRIES];
  logic [kvt_pkg::TABLE_ENTRIES-1:0]    valid_r;
  kvt_pkg::slot_t                       rd_data_r;
  logic                                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= slot_mem[mem_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (mem_req.rd_en) begin
        rd_valid_r <= valid_r[mem_req.rd_addr];
      end
      if (mem_req.clr_all) begin
        valid_r <= '0;
      end else if (mem_req.wr_en) begin
        valid_r[mem_req.wr_addr] <= 1'b1;
      end else if (mem_req.inval_en) begin
        valid_r[mem_req.wr_addr] <= 1'b0;
      end
    end
  end

  assign mem_rsp.valid = rd_valid_r;
  assign mem_rsp.data  = rd_data_r;

endmodule

FILE: hw/rtl/kvt_ctrl.sv
// sequencer: slot scan, match and free-slot tracking, write-back and result
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  kvt_pkg::key_t     in_key,
  input  kvt_pkg::value_t   in_val,
  output kvt_pkg::mem_req_t mem_req,
  input  kvt_pkg::mem_rsp_t mem_rsp,
  output logic              res_valid,
  input  logic              res_ready,
  output kvt_pkg::res_t     res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  state_t              state_r;
  kvt_pkg::op_t        op_r;
  kvt_pkg::key_t       key_r;
  kvt_pkg::value_t     val_r;
  kvt_pkg::idx_t       rd_idx_r;
  logic                chk_r;
  kvt_pkg::idx_t       chk_idx_r;
  logic                hit_r;
  kvt_pkg::idx_t       hit_idx_r;
  kvt_pkg::value_t     hit_val_r;
  logic                free_r;
  kvt_pkg::idx_t       free_idx_r;
  kvt_pkg::cnt_t       count_r;
  kvt_pkg::cnt_t       count_nxt;
  kvt_pkg::res_t       res_r;
  kvt_pkg::res_t       res_nxt;
  kvt_pkg::op_t        in_op_t;
  logic                need_scan;
  logic                hit_now;
  logic                free_now;
  logic                wr_en;
  logic                inval_en;
  logic                clr_all;
  kvt_pkg::idx_t       wr_addr;
  kvt_pkg::value_t     wr_val;

  assign in_op_t   = kvt_pkg::op_t'(in_op);
  assign need_scan = in_op_t inside {kvt_pkg::OP_INSERT, kvt_pkg::OP_ACCESS,
                                     kvt_pkg::OP_CONTAINS, kvt_pkg::OP_ERASE};
  assign in_ready  = (state_r == ST_IDLE);

  assign hit_now  = chk_r && mem_rsp.valid && (mem_rsp.data.key == key_r) && !hit_r;
  assign free_now = chk_r && !mem_rsp.valid && !free_r;

  // write-back and result decision, applied in the update state once any scan is complete
  always_comb begin
    count_nxt = count_r;
    wr_en     = 1'b0;
    inval_en  = 1'b0;
    clr_all   = 1'b0;
    wr_addr   = hit_idx_r;
    wr_val    = val_r;
    res_nxt   = '0;
    unique case (op_r)
      kvt_pkg::OP_INSERT: begin
        if (hit_r) begin
          res_nxt.found = 1'b1;
          wr_en         = 1'b1;
        end else if (free_r) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx_r;
          count_nxt = count_r + 1'b1;
        end else begin
          res_nxt.rejected = 1'b1;
        end
      end
      kvt_pkg::OP_ACCESS: begin
        if (hit_r) begin
          res_nxt.found     = 1'b1;
          res_nxt.value_out = 32'(hit_val_r);
        end else if (free_r) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx_r;
          wr_val    = '0;
          count_nxt = count_r + 1'b1;
        end else begin
          res_nxt.rejected = 1'b1;
        end
      end
      kvt_pkg::OP_CONTAINS: begin
        res_nxt.found = hit_r;
      end
      kvt_pkg::OP_ERASE: begin
        if (hit_r) begin
          res_nxt.found = 1'b1;
          inval_en      = 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      kvt_pkg::OP_CLEAR: begin
        clr_all   = 1'b1;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    res_nxt.entry_count = 5'(count_nxt);
    res_nxt.is_empty    = (count_nxt == '0);
  end

  assign mem_req.rd_en        = (state_r == ST_SCAN);
  assign mem_req.rd_addr      = rd_idx_r;
  assign mem_req.wr_en        = (state_r == ST_UPDATE) && wr_en;
  assign mem_req.inval_en     = (state_r == ST_UPDATE) && inval_en;
  assign mem_req.clr_all      = (state_r == ST_UPDATE) && clr_all;
  assign mem_req.wr_addr      = wr_addr;
  assign mem_req.wr_data.key  = key_r;
  assign mem_req.wr_data.value = wr_val;

  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      chk_r   <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      chk_r     <= (state_r == ST_SCAN);
      chk_idx_r <= rd_idx_r;
      if (hit_now) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_val_r <= mem_rsp.data.value;
      end
      if (free_now) begin
        free_r     <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op_t;
            key_r    <= in_key;
            val_r    <= in_val;
            rd_idx_r <= '0;
            hit_r    <= 1'b0;
            free_r   <= 1'b0;
            state_r  <= need_scan ? ST_SCAN : ST_UPDATE;
          end
        end
        ST_SCAN: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == kvt_pkg::LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          res_r   <= res_nxt;
          count_r <= count_nxt;
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kvt_pkg::MAX_COUNT)
    else $error("pair count above table size");

  a_found_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |-> !(res_r.found && res_r.rejected))
    else $error("result both found and rejected");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && op_r == kvt_pkg::OP_CLEAR) |=> (count_r == '0))
    else $error("clear left pairs counted");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |-> (res_r.is_empty == (count_r == '0)))
    else $error("empty flag disagrees with pair count");

endmodule

FILE: hw/rtl/key_value_table_unit.sv
// top level of the key/value table: stream ports, result register, slot store and sequencer
//
// Holds up to TABLE_ENTRIES unique key/value pairs in one synchronous slot
// memory plus a valid flag per slot. Each input beat carries an operation in
// in_tuser (insert/update, access, contains, erase, clear) with key and value
// in in_tdata, and yields exactly one result beat. An operation that needs a
// lookup reads every slot once through the single memory read port, in
// order: it takes the beat, reads each slot in turn, waits out the read
// latency in a drain state, writes back and then hands the result over.
// Clear and unused codes skip the scan. The result sits in an output
// register, so the next beat is taken while the previous result waits on
// out_tready; a second result stalls the input until that register drains.
// New pairs go into the lowest free slot; a new key into a full table is
// rejected.
module key_value_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key [31:0], value_in [63:32]
  input  logic [2:0]  in_tuser,   // operation [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // found, value_out, rejected, entry_count, is_empty
);

  kvt_pkg::mem_req_t mem_req;
  kvt_pkg::mem_rsp_t mem_rsp;
  kvt_pkg::res_t     res;
  kvt_pkg::res_t     out_res_r;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;
  kvt_pkg::key_t     in_key;
  kvt_pkg::value_t   in_val;

  // key and value fields already match the stored widths and pass through unchanged
  assign in_key = kvt_pkg::key_t'($signed(in_tdata[31:0]));
  assign in_val = kvt_pkg::value_t'(in_tdata[63:32]);

  kvt_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_key    (in_key),
    .in_val    (in_val),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule
